/* rtl/core/epso_pkg.sv */
// ---------------------------------------------------------------------------
// epso_pkg: shared constants and table builders for the sine oscillator
// Holds default sizes, config register indexes and the constant functions
// that fill the exp2 and quarter-wave sine tables at elaboration.
// ---------------------------------------------------------------------------
package epso_pkg;

    // default sizes
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int EXP_TABLE_BITS_DEF  = 8;
    localparam int OUT_WIDTH_DEF       = 16;

    // config port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_KNOB_OFFSET     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_INCREMENT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_INCREMENT = 2'd2;

    localparam logic [31:0] BASE_INCREMENT_RESET  = 32'd23409861;
    localparam logic [31:0] BLINK_INCREMENT_RESET = 32'd89478;

    // pitch format: 1/4096 octave, clamp at four octaves
    localparam int PITCH_W         = 16;
    localparam int PITCH_FRAC_BITS = 12;
    localparam int PITCH_LIMIT     = 16384;
    localparam int KNOB_W          = 13;
    localparam int KNOB_OCT_W      = 15;
    // reciprocal of three in Q0.16, exact for the knob range after rounding
    localparam logic [15:0] RECIP3_Q16 = 16'd21846;

    // increment = (base * e) >> (34 - octave)
    localparam int INC_SHIFT_BASE = 34;

    localparam logic [63:0] LN2_Q30    = 64'd744261118;
    localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30    = 64'd1073741824;

    // 2^(idx / 2^tbits) in Q2.30, truncated Taylor series
    function automatic logic [31:0] exp_entry(input int unsigned idx,
                                              input int unsigned tbits);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        x    = (LN2_Q30 * 64'(idx)) >> tbits;
        term = ONE_Q30;
        sum  = ONE_Q30;
        for (int k = 1; k < 40; k++) begin
            if (term != 64'd0) begin
                term = ((term * x) >> 30) / 64'(k);
                sum  = sum + term;
            end
        end
        return sum[31:0];
    endfunction

    // round(amp * sin(idx/2^tbits * pi/2)), sine from an integer Taylor series
    function automatic logic [22:0] sine_entry(input int unsigned idx,
                                               input int unsigned tbits,
                                               input logic [63:0] amp);
        logic [63:0] th;
        logic [63:0] term;
        logic [63:0] v;
        longint      sum;
        th   = (HALFPI_Q30 * 64'(idx)) >> tbits;
        term = th;
        sum  = longint'(th);
        for (int k = 1; k < 40; k++) begin
            if (term != 64'd0) begin
                term = (term * th) >> 30;
                term = ((term * th) >> 30) / 64'((2 * k) * (2 * k + 1));
                if ((k % 2) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(ONE_Q30)) begin
            sum = longint'(ONE_Q30);
        end
        v = ((64'(sum) * amp) + (64'd1 << 29)) >> 30;
        if (v > amp) begin
            v = amp;
        end
        return v[22:0];
    endfunction

endpackage

/* rtl/core/exp_pitch_sine_oscillator.sv */
// ---------------------------------------------------------------------------
// exp_pitch_sine_oscillator: 1 V/octave phase-accumulator sine oscillator
// Pitch word plus knob offset, clamped to four octaves, sets the phase step
// through an exp2 table; a quarter-wave table gives the sine, and a second
// accumulator gives a 1 Hz half-duty blink flag.
// ---------------------------------------------------------------------------
// Pipeline: nine register stages; a word accepted into stage 1 moves through
//   stages 2 to 9 in order and then waits on m_tdata with m_tvalid high.
// Throughput: one word per cycle while m_tready holds; the phase accumulators
//   are single adds in stage six; each stage hands on as soon as the next frees up.
// Reset (aresetn low, synchronous): all stages empty, both phases zero,
//   knob offset 0, base and blink increments back to their C4 / 1 Hz values.
// ---------------------------------------------------------------------------
module exp_pitch_sine_oscillator #(
    parameter int SINE_TABLE_BITS = epso_pkg::SINE_TABLE_BITS_DEF,
    parameter int EXP_TABLE_BITS  = epso_pkg::EXP_TABLE_BITS_DEF,
    parameter int OUT_WIDTH       = epso_pkg::OUT_WIDTH_DEF,
    localparam int TDATA_W        = ((OUT_WIDTH + 8) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // config write port
    input  logic                               cfg_we,
    input  logic [epso_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [epso_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // pitch words in
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [epso_pkg::PITCH_W-1:0]       s_tdata,   // [15:0] pitch_cv
    // sine words out
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [TDATA_W-1:0]                 m_tdata    // sine_out, blink_on, zero pad
);
    import epso_pkg::*;

    localparam int NSTAGE  = 9;
    localparam int EXP_N   = 1 << EXP_TABLE_BITS;
    localparam int EXP_R   = PITCH_FRAC_BITS - EXP_TABLE_BITS;
    localparam int EXP_IW  = EXP_TABLE_BITS + 1;
    localparam int SINE_N  = 1 << SINE_TABLE_BITS;
    localparam int SINE_R  = 30 - SINE_TABLE_BITS;
    localparam int SINE_IW = SINE_TABLE_BITS + 1;
    localparam int AMP_W   = OUT_WIDTH - 1;
    localparam logic [63:0] AMP = (64'd1 << AMP_W) - 64'd1;

    localparam logic signed [16:0] PITCH_HI = 17'(PITCH_LIMIT);
    localparam logic signed [16:0] PITCH_LO = -17'(PITCH_LIMIT);
    localparam logic [PITCH_FRAC_BITS-1:0] EXP_REM_MASK =
        PITCH_FRAC_BITS'((1 << EXP_R) - 1);

    // -----------------------------------------------------------------------
    // Constant tables, built at elaboration
    // -----------------------------------------------------------------------
    logic [31:0]      exp_tab  [EXP_N+1];
    logic [AMP_W-1:0] sine_tab [SINE_N+1];

    for (genvar gi = 0; gi <= EXP_N; gi++) begin : g_exp_tab
        localparam logic [31:0] ENTRY = exp_entry(gi, EXP_TABLE_BITS);
        assign exp_tab[gi] = ENTRY;
    end

    for (genvar gi = 0; gi <= SINE_N; gi++) begin : g_sine_tab
        localparam logic [22:0] ENTRY = sine_entry(gi, SINE_TABLE_BITS, AMP);
        assign sine_tab[gi] = ENTRY[AMP_W-1:0];
    end

    // -----------------------------------------------------------------------
    // Config registers. The knob is held already converted to pitch units:
    // round(knob * 4/3), done as sign * floor((4|k| + 1) / 3).
    // -----------------------------------------------------------------------
    function automatic logic signed [KNOB_OCT_W-1:0] knob_to_pitch(
        input logic [KNOB_W-1:0] knob);
        logic [KNOB_W-1:0]     mag;
        logic [KNOB_OCT_W-1:0] num;
        logic [29:0]           prod;
        logic [13:0]           quo;
        mag  = knob[KNOB_W-1] ? (~knob + 1'b1) : knob;
        num  = {mag, 2'b01};
        prod = 30'(num) * 30'(RECIP3_Q16);
        quo  = prod[29:16];
        return knob[KNOB_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    endfunction

    logic signed [KNOB_OCT_W-1:0] knob_pitch_reg;
    logic [31:0]                  base_inc_reg;
    logic [31:0]                  blink_inc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            knob_pitch_reg <= '0;
            base_inc_reg   <= BASE_INCREMENT_RESET;
            blink_inc_reg  <= BLINK_INCREMENT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_KNOB_OFFSET:     knob_pitch_reg <= knob_to_pitch(cfg_wdata[KNOB_W-1:0]);
                CFG_BASE_INCREMENT:  base_inc_reg   <= cfg_wdata;
                CFG_BLINK_INCREMENT: blink_inc_reg  <= cfg_wdata;
                default: ;  // unused index: drop the write
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Stage handshake: a stage takes a new word when it is empty or its
    // current word moves on in the same cycle.
    // -----------------------------------------------------------------------
    logic [NSTAGE:1] vld_reg;
    logic [NSTAGE:1] stage_rdy;
    logic [NSTAGE:1] vld_in;
    logic [NSTAGE:1] load;

    always_comb begin
        stage_rdy[NSTAGE] = !vld_reg[NSTAGE] || m_tready;
        for (int i = NSTAGE - 1; i >= 1; i--) begin
            stage_rdy[i] = !vld_reg[i] || stage_rdy[i+1];
        end
    end

    assign vld_in   = {vld_reg[NSTAGE-1:1], s_tvalid};
    assign load     = stage_rdy & vld_in;
    assign s_tready = stage_rdy[1];
    assign m_tvalid = vld_reg[NSTAGE];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int i = 1; i <= NSTAGE; i++) begin
                if (stage_rdy[i]) begin
                    vld_reg[i] <= vld_in[i];
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stage 1: add knob, clamp to four octaves, offset to 0..8 octaves
    // -----------------------------------------------------------------------
    logic signed [16:0]   pitch_sum;
    logic signed [16:0]   pitch_clamp;
    logic [PITCH_W-1:0]   p1_next;
    logic [PITCH_W-1:0]   p1_reg;

    always_comb begin
        pitch_sum = 17'($signed(s_tdata)) + 17'(knob_pitch_reg);
        if (pitch_sum > PITCH_HI) begin
            pitch_clamp = PITCH_HI;
        end else if (pitch_sum < PITCH_LO) begin
            pitch_clamp = PITCH_LO;
        end else begin
            pitch_clamp = pitch_sum;
        end
        p1_next = PITCH_W'(pitch_clamp + PITCH_HI);
    end

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            p1_reg <= p1_next;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 2: exp2 table lookup and interpolation step on the fraction
    // -----------------------------------------------------------------------
    logic [PITCH_FRAC_BITS-1:0] frac2;
    logic [PITCH_FRAC_BITS-1:0] rem2;
    logic [EXP_IW-1:0]          eidx_lo;
    logic [EXP_IW-1:0]          eidx_hi;
    logic [31:0]                ediff;
    logic [43:0]                eprod;
    logic [31:0]                e_base2_reg;
    logic [31:0]                e_frac2_reg;
    logic [3:0]                 oct2_reg;

    always_comb begin
        frac2   = p1_reg[PITCH_FRAC_BITS-1:0];
        rem2    = frac2 & EXP_REM_MASK;
        eidx_lo = {1'b0, frac2[PITCH_FRAC_BITS-1:EXP_R]};
        eidx_hi = eidx_lo + 1'b1;
        ediff   = exp_tab[eidx_hi] - exp_tab[eidx_lo];
        eprod   = (44'(ediff) * 44'(rem2)) >> EXP_R;
    end

    always_ff @(posedge aclk) begin
        if (load[2]) begin
            e_base2_reg <= exp_tab[eidx_lo];
            e_frac2_reg <= eprod[31:0];
            oct2_reg    <= p1_reg[PITCH_W-1:PITCH_FRAC_BITS];
        end
    end

    // Stage 3: finish the interpolated 2^frac
    logic [31:0] e3_reg;
    logic [3:0]  oct3_reg;

    always_ff @(posedge aclk) begin
        if (load[3]) begin
            e3_reg   <= e_base2_reg + e_frac2_reg;
            oct3_reg <= oct2_reg;
        end
    end

    // Stage 4: scale the C4 increment
    logic [63:0] prod4_reg;
    logic [3:0]  oct4_reg;

    always_ff @(posedge aclk) begin
        if (load[4]) begin
            prod4_reg <= 64'(base_inc_reg) * 64'(e3_reg);
            oct4_reg  <= oct3_reg;
        end
    end

    // Stage 5: octave shift, saturate just below half a cycle
    logic [5:0]  shift5;
    logic [63:0] shifted5;
    logic [30:0] inc5_next;
    logic [30:0] inc5_reg;

    always_comb begin
        shift5    = 6'(INC_SHIFT_BASE) - {2'b00, oct4_reg};
        shifted5  = prod4_reg >> shift5;
        inc5_next = (|shifted5[63:31]) ? '1 : shifted5[30:0];
    end

    always_ff @(posedge aclk) begin
        if (load[5]) begin
            inc5_reg <= inc5_next;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 6: the accumulators themselves; they advance once per word and
    // hold that word's new phases until it moves on.
    // -----------------------------------------------------------------------
    logic [31:0] osc_phase_reg;
    logic [31:0] blink_phase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            osc_phase_reg   <= '0;
            blink_phase_reg <= '0;
        end else if (load[6]) begin
            osc_phase_reg   <= osc_phase_reg + {1'b0, inc5_reg};
            blink_phase_reg <= blink_phase_reg + blink_inc_reg;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 7: fold to the first quadrant, sine table lookup. The top of the
    // quarter wave (odd quadrant, zero position) reads the last entry alone.
    // -----------------------------------------------------------------------
    logic [30:0]        sx;
    logic [SINE_IW-1:0] sidx_lo;
    logic [SINE_IW-1:0] sidx_hi;
    logic [AMP_W-1:0]   sin_a7_reg;
    logic [AMP_W-1:0]   sin_d7_reg;
    logic [SINE_R-1:0]  sin_r7_reg;
    logic               neg7_reg;
    logic               blink7_reg;

    always_comb begin
        sx      = osc_phase_reg[30] ? (31'h4000_0000 - {1'b0, osc_phase_reg[29:0]})
                                    : {1'b0, osc_phase_reg[29:0]};
        sidx_lo = sx[30:SINE_R];
        sidx_hi = sidx_lo[SINE_IW-1] ? sidx_lo : (sidx_lo + 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (load[7]) begin
            sin_a7_reg <= sine_tab[sidx_lo];
            sin_d7_reg <= sine_tab[sidx_hi] - sine_tab[sidx_lo];
            sin_r7_reg <= sx[SINE_R-1:0];
            neg7_reg   <= osc_phase_reg[31];
            blink7_reg <= ~blink_phase_reg[31];
        end
    end

    // Stage 8: interpolation step between table entries
    logic [AMP_W+SINE_R-1:0] sprod8;
    logic [AMP_W-1:0]        sin_a8_reg;
    logic [AMP_W-1:0]        sin_i8_reg;
    logic                    neg8_reg;
    logic                    blink8_reg;

    assign sprod8 = (AMP_W+SINE_R)'(sin_d7_reg) * (AMP_W+SINE_R)'(sin_r7_reg);

    always_ff @(posedge aclk) begin
        if (load[8]) begin
            sin_a8_reg <= sin_a7_reg;
            sin_i8_reg <= sprod8[SINE_R +: AMP_W];
            neg8_reg   <= neg7_reg;
            blink8_reg <= blink7_reg;
        end
    end

    // Stage 9: magnitude, sign from the upper half cycle, pack the word
    logic [AMP_W-1:0]     mag9;
    logic [OUT_WIDTH-1:0] sine9;
    logic [TDATA_W-1:0]   m_tdata_reg;

    always_comb begin
        mag9  = sin_a8_reg + sin_i8_reg;
        sine9 = neg8_reg ? -{1'b0, mag9} : {1'b0, mag9};
    end

    always_ff @(posedge aclk) begin
        if (load[9]) begin
            m_tdata_reg <= TDATA_W'({blink8_reg, sine9});
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

/* rtl/core/epso_checker.sv */
// ---------------------------------------------------------------------------
// epso_checker: port-level checks for the sine oscillator
// Watches the stream ports of the top level; attached by the bind below.
// ---------------------------------------------------------------------------
module epso_checker #(
    parameter int OUT_WIDTH = 16,
    parameter int TDATA_W   = 24
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    localparam logic [OUT_WIDTH-1:0] MOST_NEG = {1'b1, {(OUT_WIDTH-1){1'b0}}};

    // the pipe comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_tvalid)
        else $error("output word valid right after reset");

    // a stalled output word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output word changed");

    // whenever the output side drains, the input side is ready for a word
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input held off while output drains");

    // the sine is symmetric: the most negative code never appears
    a_sine_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_WIDTH-1:0] != MOST_NEG))
        else $error("sine word outside full scale");

endmodule

bind exp_pitch_sine_oscillator epso_checker #(
    .OUT_WIDTH (OUT_WIDTH),
    .TDATA_W   (TDATA_W)
) u_epso_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for exp_pitch_sine_oscillator
// Streams pitch words into the oscillator, predicts every sine/blink word
// with an independent fixed-point model of the NCO (exp2 pitch scaling,
// quarter-wave sine lookup, 1 Hz blink accumulator) and compares each word
// that leaves the block against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_top;

    // sizes the block is built with (its default parameters)
    localparam int SINE_ADDR_BITS = 10;
    localparam int EXP_ADDR_BITS  = 8;
    localparam int SINE_W         = 16;
    localparam int TDATA_BITS     = 24;
    localparam int SINE_POINTS    = 1 << SINE_ADDR_BITS;
    localparam int EXP_POINTS     = 1 << EXP_ADDR_BITS;

    // fixed-point constants of the oscillator
    localparam longint unsigned LN2_FX     = 64'd744261118;
    localparam longint unsigned HALFPI_FX  = 64'd1686629713;
    localparam longint unsigned UNIT_FX    = 64'd1 << 30;
    localparam longint unsigned SINE_PEAK  = (64'd1 << (SINE_W - 1)) - 64'd1;
    localparam longint unsigned STEP_MAX   = 64'h7FFF_FFFF;
    localparam int              OCT_CLAMP  = 16384;

    // register index the block does not decode
    localparam logic [epso_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    // receiver hold-off used to back the pipeline up
    localparam int HOLD_OFF_CYCLES = 120;
    // extra cycles after the last word, well over the depth of the nine-stage pipeline
    localparam int TAIL_CYCLES     = 20;

    typedef struct packed {
        logic              blink;
        logic [SINE_W-1:0] sine;
    } osc_word_t;

    // ------------------------------------------------------------------
    // DUT ports; every DUT input is known from time zero
    // ------------------------------------------------------------------
    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              cfg_we    = 1'b0;
    logic [epso_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [epso_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [epso_pkg::PITCH_W-1:0]      s_tdata   = '0;   // [15:0] pitch_cv
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [TDATA_BITS-1:0]             m_tdata;          // [15:0] sine_out, [16] blink_on

    exp_pitch_sine_oscillator DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ------------------------------------------------------------------
    // Oscillator model state
    // ------------------------------------------------------------------
    longint unsigned exp2_rom [EXP_POINTS + 1];
    longint unsigned quarter_sine_rom [SINE_POINTS + 1];

    int          knob_setting = 0;
    logic [31:0] base_step    = epso_pkg::BASE_INCREMENT_RESET;
    logic [31:0] blink_step   = epso_pkg::BLINK_INCREMENT_RESET;
    logic [31:0] osc_acc      = '0;
    logic [31:0] blink_acc    = '0;

    osc_word_t   pending_samples [$];
    int          error_count    = 0;
    int          words_seen     = 0;

    // idling odds in percent per cycle
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    logic        hold_off       = 1'b0;
    event        hold_off_start;

    // ------------------------------------------------------------------
    // Clock: 2 ns period
    // ------------------------------------------------------------------
    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Fill the model tables once at time zero; nothing reads them before
    // reset is released.
    // ------------------------------------------------------------------
    initial begin
        longint unsigned x, term, sum, v;
        longint          acc;
        // exp2 table: 2^(i/256) in Q2.30 from a truncated Taylor series
        for (int i = 0; i <= EXP_POINTS; i++) begin
            x    = (LN2_FX * 64'(i)) >> EXP_ADDR_BITS;
            term = UNIT_FX;
            sum  = UNIT_FX;
            for (int k = 1; k < 40 && term != 0; k++) begin
                term = ((term * x) >> 30) / 64'(k);
                sum  = sum + term;
            end
            exp2_rom[i] = sum;
        end
        // quarter-wave table: sin series in Q2.30, scaled to full scale
        for (int i = 0; i <= SINE_POINTS; i++) begin
            x    = (HALFPI_FX * 64'(i)) >> SINE_ADDR_BITS;
            term = x;
            acc  = longint'(x);
            for (int k = 1; k < 40 && term != 0; k++) begin
                term = (term * x) >> 30;
                term = ((term * x) >> 30) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            if (acc > longint'(UNIT_FX)) begin
                acc = longint'(UNIT_FX);
            end
            v = ((64'(acc) * SINE_PEAK) + (64'd1 << 29)) >> 30;
            if (v > SINE_PEAK) begin
                v = SINE_PEAK;
            end
            quarter_sine_rom[i] = v;
        end
    end

    // ------------------------------------------------------------------
    // Advance both accumulators by one pitch word and return the word the
    // block must produce for it.
    // ------------------------------------------------------------------
    function automatic osc_word_t next_sample(input logic signed [15:0] cv);
        int              knob4, knob_oct, pitch;
        int unsigned     p, octave, frac, eidx, erem, sidx;
        longint unsigned e, step, mag, srem;
        logic [31:0]     pos, x;
        logic [1:0]      quad;
        osc_word_t       w;
        // knob in 1/256 semitone to 1/4096 octave, rounded half away from zero
        knob4    = knob_setting * 4;
        knob_oct = (knob4 >= 0) ? (knob4 + 1) / 3 : (knob4 - 1) / 3;
        pitch    = int'(cv) + knob_oct;
        if (pitch > OCT_CLAMP) begin
            pitch = OCT_CLAMP;
        end
        if (pitch < -OCT_CLAMP) begin
            pitch = -OCT_CLAMP;
        end
        // octave selects the shift, fraction indexes and interpolates exp2
        p      = unsigned'(pitch + OCT_CLAMP);
        octave = p >> 12;
        frac   = p & 12'hFFF;
        eidx   = frac >> (12 - EXP_ADDR_BITS);
        erem   = frac & ((1 << (12 - EXP_ADDR_BITS)) - 1);
        e      = exp2_rom[eidx];
        if (eidx < EXP_POINTS) begin
            e = e + (((exp2_rom[eidx + 1] - exp2_rom[eidx]) * 64'(erem))
                     >> (12 - EXP_ADDR_BITS));
        end
        step = (64'(base_step) * e) >> (34 - octave);
        // hold the step just under half a cycle
        if (step > STEP_MAX) begin
            step = STEP_MAX;
        end
        // both accumulators move first; the outputs use the new phases
        osc_acc   = osc_acc + step[31:0];
        blink_acc = blink_acc + blink_step;
        // fold the phase into the first quadrant
        quad = osc_acc[31:30];
        pos  = {2'b00, osc_acc[29:0]};
        x    = quad[0] ? (32'h4000_0000 - pos) : pos;
        sidx = x >> (30 - SINE_ADDR_BITS);
        srem = 64'(x & ((32'd1 << (30 - SINE_ADDR_BITS)) - 32'd1));
        if (sidx >= SINE_POINTS) begin
            mag = quarter_sine_rom[SINE_POINTS];
        end else begin
            mag = quarter_sine_rom[sidx]
                + (((quarter_sine_rom[sidx + 1] - quarter_sine_rom[sidx]) * srem)
                   >> (30 - SINE_ADDR_BITS));
        end
        w.sine = mag[SINE_W-1:0];
        if (quad[1]) begin
            w.sine = -w.sine;
        end
        w.blink = (blink_acc < 32'h8000_0000);
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t word %0d: %s", $realtime, words_seen, what);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, or a long hold-off while one is requested
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_off) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Count out the hold-off in its own process.
    initial begin
        forever begin
            @(hold_off_start);
            hold_off <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            hold_off <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Checker: match every accepted word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        osc_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_samples.size() == 0) begin
                report_mismatch($sformatf("word %h with nothing expected", m_tdata));
            end else begin
                want = pending_samples.pop_front();
                if (m_tdata[SINE_W-1:0] !== want.sine) begin
                    report_mismatch($sformatf("sine_out got %h want %h",
                                              m_tdata[SINE_W-1:0], want.sine));
                end
                if (m_tdata[SINE_W] !== want.blink) begin
                    report_mismatch($sformatf("blink_on got %b want %b",
                                              m_tdata[SINE_W], want.blink));
                end
                if (m_tdata[TDATA_BITS-1:SINE_W+1] !== '0) begin
                    report_mismatch($sformatf("pad bits got %h",
                                              m_tdata[TDATA_BITS-1:SINE_W+1]));
                end
            end
            words_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Sender: idle at random, offer one pitch word, hold it until taken,
    // then log its prediction. Valid stays high for a back-to-back word.
    // ------------------------------------------------------------------
    task automatic send_pitch(input logic [15:0] cv);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cv;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pending_samples.push_back(next_sample(cv));
    endtask

    // Drop valid and wait until every predicted word has come back.
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending_samples.size() != 0);
    endtask

    // Write one register with the pipeline empty and mirror it in the model.
    task automatic write_reg(input logic [epso_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] value);
        drain_outputs();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            epso_pkg::CFG_KNOB_OFFSET: begin
                knob_setting = int'($signed(value[12:0]));
            end
            epso_pkg::CFG_BASE_INCREMENT: begin
                base_step = value;
            end
            epso_pkg::CFG_BLINK_INCREMENT: begin
                blink_step = value;
            end
            default: begin
                // undecoded index: the block ignores it
            end
        endcase
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct <= receiver_pct;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Pitch corners at reset settings: clamp edges, both field extremes,
    // octave boundaries and interpolation remainders.
    task automatic test_pitch_extremes();
        logic [15:0] corners [14] = '{
            16'h0000, 16'h0001, 16'hFFFF, 16'h3FFF, 16'h4000, 16'h4001,
            16'hC001, 16'hC000, 16'hBFFF, 16'h7FFF, 16'h8000, 16'h0FFF,
            16'h5555, 16'hAAAA
        };
        foreach (corners[i]) begin
            send_pitch(corners[i]);
        end
    endtask

    // Base and blink increments at their extremes; the largest base
    // saturates the phase step at the top octave.
    task automatic test_increment_extremes();
        write_reg(epso_pkg::CFG_BASE_INCREMENT, 32'hFFFF_FFFF);
        send_pitch(16'h4000);
        send_pitch(16'hC000);
        write_reg(epso_pkg::CFG_BASE_INCREMENT, 32'h0000_0000);
        send_pitch(16'h1234);
        write_reg(epso_pkg::CFG_BASE_INCREMENT, epso_pkg::BASE_INCREMENT_RESET);
        write_reg(epso_pkg::CFG_BLINK_INCREMENT, 32'hFFFF_FFFF);
        send_pitch(16'h0800);
        write_reg(epso_pkg::CFG_BLINK_INCREMENT, 32'h0000_0000);
        send_pitch(16'hF800);
    endtask

    // Knob at both 13-bit extremes, its nominal range, and with junk above
    // bit 12 of the write data.
    task automatic test_knob_offset();
        logic [31:0] knobs [5] = '{
            32'h0000_0FFF, 32'h0000_1000, 32'h0000_0C00, 32'hFFFF_F400, 32'hABCD_E001
        };
        logic [15:0] pitches [5] = '{16'h3E80, 16'hC180, 16'h0400, 16'hFC00, 16'h7000};
        foreach (knobs[i]) begin
            write_reg(epso_pkg::CFG_KNOB_OFFSET, knobs[i]);
            send_pitch(pitches[i]);
        end
        write_reg(epso_pkg::CFG_KNOB_OFFSET, 32'd0);
    endtask

    // A write to an undecoded index must change nothing.
    task automatic test_unknown_register();
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        send_pitch(16'h2000);
    endtask

    // Random pitch words, with a fresh random setting every block of words.
    task automatic test_random_pitch(input int count);
        int          kind;
        int          value;
        logic [31:0] knob, base, blink;
        for (int n = 0; n < count; n++) begin
            if (n % 90 == 0) begin
                // mostly in-range knob and audio-rate bases, now and then anything
                knob  = $urandom_range(3) == 0 ? $urandom
                                               : 32'(int'($urandom_range(6144)) - 3072);
                base  = $urandom_range(4) == 0 ? $urandom
                                               : $urandom_range(32'h0200_0000, 32'h0000_1000);
                blink = $urandom_range(3) == 0 ? $urandom
                                               : $urandom_range(32'h4000_0000, 32'h0400_0000);
                write_reg(epso_pkg::CFG_KNOB_OFFSET, knob);
                write_reg(epso_pkg::CFG_BASE_INCREMENT, base);
                write_reg(epso_pkg::CFG_BLINK_INCREMENT, blink);
            end
            kind = $urandom_range(9);
            if (kind < 5) begin
                // inside the four-octave window
                value = int'($urandom_range(2 * OCT_CLAMP)) - OCT_CLAMP;
            end else if (kind < 8) begin
                // any 16-bit word, half of them clamped
                value = int'($urandom_range(16'hFFFF));
            end else begin
                // hug the clamp edges
                value = ($urandom_range(1) ? OCT_CLAMP : -OCT_CLAMP)
                      + int'($urandom_range(64)) - 32;
            end
            send_pitch(value[15:0]);
        end
    endtask

    // Hold the receiver off for a long stretch while the sender keeps
    // offering words back to back, so the pipeline fills and stalls input.
    task automatic test_backpressure();
        drain_outputs();
        -> hold_off_start;
        for (int n = 0; n < 40; n++) begin
            send_pitch(16'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        // hold reset low, then release it
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        set_idling(22, 54);
        test_pitch_extremes();
        test_increment_extremes();
        test_knob_offset();
        test_unknown_register();
        test_random_pitch(360);

        set_idling(54, 22);
        test_random_pitch(360);

        set_idling(0, 0);
        test_random_pitch(360);
        test_backpressure();

        drain_outputs();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("exp_pitch_sine_oscillator test passed");
        end else begin
            $display("exp_pitch_sine_oscillator test failed");
        end
        $finish;
    end

    // Give up on a hung handshake long after a correct run would end.
    initial begin
        #2_000_000;
        $display("exp_pitch_sine_oscillator test failed");
        $finish;
    end

endmodule
